### rtl/core/skc_pkg.sv
// shared types, constants and the exponent root table of the soft knee compressor
`default_nettype none

package skc_pkg;

   // shared multiplier operand and product widths
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // knee divider widths
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 18;
   localparam int DIV_Q_W   = 16;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W);

   // configuration register indexes
   localparam logic [2:0] CSR_THRESHOLD  = 3'd0;
   localparam logic [2:0] CSR_KNEE       = 3'd1;
   localparam logic [2:0] CSR_INV_RATIO  = 3'd2;
   localparam logic [2:0] CSR_ATTACK     = 3'd3;
   localparam logic [2:0] CSR_ATTACK_SLW = 3'd4;
   localparam logic [2:0] CSR_RELEASE    = 3'd5;

   // configuration reset values
   localparam logic [15:0] RST_INV_RATIO  = 16'd43691;
   localparam logic [15:0] RST_ATTACK     = 16'd65399;
   localparam logic [15:0] RST_ATTACK_SLW = 16'd65399;
   localparam logic [15:0] RST_RELEASE    = 16'd65518;

   // arithmetic constants
   localparam logic signed [16:0] LEVEL_ZERO   = -17'sd40960;  // -160 dB
   localparam logic [19:0]        LOG_TOP      = 20'd983040;   // 15 octaves in q.16
   localparam logic [MUL_W-1:0]   DB_PER_OCT   = 33'd394566;   // 20*log10(2) q.16
   localparam logic [MUL_W-1:0]   OCT_PER_DB   = 33'd174165;   // log2(10)/20 q.20
   localparam logic signed [19:0] SLEW_LIMIT   = 20'sd461;     // 1.8 dB
   localparam logic [14:0]        WIDTH_OFFSET = 15'd3;        // 0.01 dB

   typedef logic [30:0] root_tab_type [16];

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOG_SQ,
      ST_LOG_ACC,
      ST_LOG_DB,
      ST_LOG_LVL,
      ST_CURVE_E,
      ST_CURVE_SEL,
      ST_CURVE_HI,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_KNEE_MUL,
      ST_KNEE_CURVE,
      ST_REDUCE,
      ST_PEAK_MUL,
      ST_PEAK,
      ST_ATK_MUL,
      ST_ATK,
      ST_EXP_MUL,
      ST_EXP_T,
      ST_GAIN_CHK,
      ST_GAIN_UPD,
      ST_SCALE,
      ST_OUT,
      ST_FINISH
   } skc_state_type;

   function automatic logic [63:0] isqrt(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      int          i;
      v = v_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // roots 2^(-2^-k) in q.30 for k = 1..16
   function automatic root_tab_type root_table();
      root_tab_type t;
      logic [63:0]  r;
      int           k;
      r = 64'd1 << 29;
      for (k = 0; k < 16; k++) begin
         r    = isqrt(r << 30);
         t[k] = r[30:0];
      end
      return t;
   endfunction

   localparam root_tab_type ROOT_TAB = root_table();

endpackage

`default_nettype wire

### rtl/core/soft_knee_log_compressor_core.sv
// soft knee log domain compressor: sequencer, datapath and configuration registers
// path: the log path runs 16 squaring steps, which silence skips; a level inside the
//    knee adds the divider, a level above it adds a scaling step, and the gain exponent
//    adds an update step per set bit of its fraction (up to 16 bits)
// a new sample is taken only in idle, once the previous result has entered the result register
// reset: synchronous, clears sequencer, detector state and loads register defaults
`default_nettype none

module soft_knee_log_compressor_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic signed [15:0]  req_in_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [15:0]       rsp_out_sample,
   output logic [14:0]              rsp_gain_reduction_db,
   input  wire logic                csr_wr_en,
   input  wire logic [2:0]          csr_index,
   input  wire logic [15:0]         csr_wdata
);
   import skc_pkg::*;

   // configuration registers
   logic signed [15:0] thresh_ff;
   logic [11:0]        knee_ff;
   logic [15:0]        inv_ff;
   logic [15:0]        atk_ff;
   logic [15:0]        slw_ff;
   logic [15:0]        rel_ff;

   // sequencer
   skc_state_type state_ff;
   skc_state_type state_in;

   // per sample working registers
   logic signed [15:0] x_ff;
   logic [15:0]        m_ff;
   logic [3:0]         p_ff;
   logic [15:0]        y_ff;
   logic [15:0]        frac_ff;
   logic [3:0]         cnt_ff;
   logic signed [16:0] level_ff;
   logic signed [17:0] e_ff;
   logic signed [19:0] curve_ff;
   logic               in_knee_ff;
   logic               near_ff;
   logic               slew_ff;
   logic [14:0]        red_in_ff;
   logic [4:0]         n_ff;
   logic [15:0]        f_ff;
   logic [30:0]        g_ff;
   logic signed [15:0] res_sample_ff;

   // detector state kept across samples
   logic signed [15:0] prev_ff;
   logic [14:0]        peak_ff;
   logic [14:0]        smooth_ff;

   // result register
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_sample_ff;
   logic [14:0]        rsp_red_ff;

   // shared units
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] mul_p;
   div_req_type              div_req;
   logic                     div_done;
   logic [DIV_Q_W-1:0]       div_quot;

   // input magnitude and leading one
   logic [15:0] in_mag;
   logic [3:0]  lead;
   logic        in_xfer;
   logic        rsp_load;

   // curve helpers
   logic [14:0]        width;
   logic signed [19:0] width_s;
   logic signed [19:0] e2_s;
   logic signed [19:0] e2_abs;
   logic signed [19:0] s_full;
   logic               below;
   logic               above;
   logic signed [19:0] level20;
   logic signed [19:0] thresh20;
   logic signed [19:0] prev20;
   logic signed [20:0] r21;
   logic [19:0]        log_d;
   logic [16:0]        inv_c;
   logic signed [16:0] peak_diff;
   logic signed [16:0] smooth_diff;
   logic [15:0]        acoef;

   // product roundings
   logic [16:0] log_sq;
   logic [40:0] lvl_sum;
   logic [32:0] hi_sum;
   logic [33:0] kn_sum;
   logic [32:0] blend_sum;
   logic [32:0] exp_sum;
   logic [61:0] gain_sum;
   logic [47:0] out_sum;
   logic [16:0] mag;
   logic [16:0] neg_mag;

   skc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   skc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   assign in_xfer  = req_valid && !req_stall;
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   assign in_mag = req_in_sample[15] ? (~req_in_sample + 16'd1) : req_in_sample;

   always_comb begin
      lead = '0;
      for (int i = 0; i < 16; i++) begin
         if (in_mag[i]) begin
            lead = 4'(i);
         end
      end
   end

   // knee width w = 6k + 0.01 dB, and the curve compares on twice the overshoot
   assign width    = ({3'b0, knee_ff} * 15'd6) + WIDTH_OFFSET;
   assign width_s  = {5'b0, width};
   assign e2_s     = {e_ff[17], e_ff, 1'b0};
   assign e2_abs   = e2_s[19] ? -e2_s : e2_s;
   assign s_full   = e2_s + width_s;
   assign below    = e2_s < -width_s;
   assign above    = e2_s > width_s;
   assign level20  = {{3{level_ff[16]}}, level_ff};
   assign thresh20 = {{4{thresh_ff[15]}}, thresh_ff};
   assign prev20   = {{4{prev_ff[15]}}, prev_ff};
   assign r21      = {level20[19], level20} - {curve_ff[19], curve_ff};
   assign log_d    = LOG_TOP - {p_ff, frac_ff};
   assign inv_c    = 17'h10000 - {1'b0, inv_ff};
   assign acoef    = slew_ff ? slw_ff : atk_ff;

   // blends are written as new + a*(old - new)
   assign peak_diff   = {2'b0, peak_ff} - {2'b0, red_in_ff};
   assign smooth_diff = {2'b0, smooth_ff} - {2'b0, peak_ff};

   assign log_sq    = mul_p[31:15];
   assign lvl_sum   = {1'b0, mul_p[39:0]} + 41'h80_0000;
   assign hi_sum    = mul_p[32:0] + 33'd32768;
   assign kn_sum    = mul_p[33:0] + 34'd32768;
   assign blend_sum = (state_ff == ST_PEAK) ?
                      ({2'b0, red_in_ff, 16'b0} + mul_p[32:0] + 33'd32768) :
                      ({2'b0, peak_ff, 16'b0} + mul_p[32:0] + 33'd32768);
   assign exp_sum   = mul_p[32:0] + 33'd2048;
   assign gain_sum  = mul_p[61:0] + 62'h2000_0000;
   assign out_sum   = mul_p[47:0] + 48'h2000_0000;
   assign mag       = out_sum[46:30];
   assign neg_mag   = 17'd0 - mag;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_xfer) begin
               state_in = (in_mag == '0) ? ST_CURVE_E : ST_LOG_SQ;
            end
         end
         ST_LOG_SQ:     state_in = ST_LOG_ACC;
         ST_LOG_ACC:    state_in = (cnt_ff == 4'd15) ? ST_LOG_DB : ST_LOG_SQ;
         ST_LOG_DB:     state_in = ST_LOG_LVL;
         ST_LOG_LVL:    state_in = ST_CURVE_E;
         ST_CURVE_E:    state_in = ST_CURVE_SEL;
         ST_CURVE_SEL: begin
            if (below) begin
               state_in = ST_REDUCE;
            end else if (above) begin
               state_in = ST_CURVE_HI;
            end else begin
               state_in = ST_DIV_START;
            end
         end
         ST_CURVE_HI:   state_in = ST_REDUCE;
         ST_DIV_START:  state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_KNEE_MUL;
            end
         end
         ST_KNEE_MUL:   state_in = ST_KNEE_CURVE;
         ST_KNEE_CURVE: state_in = ST_REDUCE;
         ST_REDUCE:     state_in = ST_PEAK_MUL;
         ST_PEAK_MUL:   state_in = ST_PEAK;
         ST_PEAK:       state_in = ST_ATK_MUL;
         ST_ATK_MUL:    state_in = ST_ATK;
         ST_ATK:        state_in = ST_EXP_MUL;
         ST_EXP_MUL:    state_in = ST_EXP_T;
         ST_EXP_T:      state_in = ST_GAIN_CHK;
         ST_GAIN_CHK: begin
            if (f_ff[15]) begin
               state_in = ST_GAIN_UPD;
            end else if (cnt_ff == 4'd15) begin
               state_in = ST_SCALE;
            end
         end
         ST_GAIN_UPD:   state_in = (cnt_ff == 4'd15) ? ST_SCALE : ST_GAIN_CHK;
         ST_SCALE:      state_in = ST_OUT;
         ST_OUT:        state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: multiplier operands, divider start, input stall
   always_comb begin
      mul_a            = '0;
      mul_b            = '0;
      div_req.start    = 1'b0;
      div_req.dividend = mul_p[DIV_NUM_W-1:0];
      div_req.divisor  = {width, 3'b0};
      req_stall        = (state_ff != ST_IDLE);
      case (state_ff)
         ST_LOG_SQ: begin
            mul_a = {17'b0, y_ff};
            mul_b = {17'b0, y_ff};
         end
         ST_LOG_DB: begin
            mul_a = {13'b0, log_d};
            mul_b = DB_PER_OCT;
         end
         ST_CURVE_SEL: begin
            if (above) begin
               mul_a = {{15{e_ff[17]}}, e_ff};
               mul_b = {17'b0, inv_ff};
            end else begin
               mul_a = {17'b0, s_full[15:0]};
               mul_b = {17'b0, s_full[15:0]};
            end
         end
         ST_DIV_START: begin
            div_req.start = 1'b1;
         end
         ST_KNEE_MUL: begin
            mul_a = {17'b0, div_quot};
            mul_b = {16'b0, inv_c};
         end
         ST_PEAK_MUL: begin
            mul_a = {17'b0, rel_ff};
            mul_b = {{16{peak_diff[16]}}, peak_diff};
         end
         ST_ATK_MUL: begin
            mul_a = {17'b0, acoef};
            mul_b = {{16{smooth_diff[16]}}, smooth_diff};
         end
         ST_EXP_MUL: begin
            mul_a = {18'b0, smooth_ff};
            mul_b = OCT_PER_DB;
         end
         ST_GAIN_CHK: begin
            mul_a = {2'b0, g_ff};
            mul_b = {2'b0, ROOT_TAB[cnt_ff]};
         end
         ST_SCALE: begin
            mul_a = {17'b0, m_ff};
            mul_b = {2'b0, g_ff >> n_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
         knee_ff   <= '0;
         inv_ff    <= RST_INV_RATIO;
         atk_ff    <= RST_ATTACK;
         slw_ff    <= RST_ATTACK_SLW;
         rel_ff    <= RST_RELEASE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_THRESHOLD:  thresh_ff <= csr_wdata;
            CSR_KNEE:       knee_ff   <= csr_wdata[11:0];
            CSR_INV_RATIO:  inv_ff    <= csr_wdata;
            CSR_ATTACK:     atk_ff    <= csr_wdata;
            CSR_ATTACK_SLW: slw_ff    <= csr_wdata;
            CSR_RELEASE:    rel_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         peak_ff   <= '0;
         smooth_ff <= '0;
      end else begin
         case (state_ff)
            ST_REDUCE: begin
               // stored curve level saturates to 16 bits
               if (curve_ff > 20'sd32767) begin
                  prev_ff <= 16'sh7FFF;
               end else if (curve_ff < -20'sd32768) begin
                  prev_ff <= -16'sh8000;
               end else begin
                  prev_ff <= curve_ff[15:0];
               end
            end
            ST_PEAK: begin
               // peak hold: never below the fresh reduction
               peak_ff <= (blend_sum[30:16] > red_in_ff) ? blend_sum[30:16] : red_in_ff;
            end
            ST_ATK: begin
               smooth_ff <= blend_sum[30:16];
            end
            default: ;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (in_xfer) begin
               x_ff     <= req_in_sample;
               m_ff     <= in_mag;
               p_ff     <= lead;
               y_ff     <= in_mag << (4'd15 - lead);
               frac_ff  <= '0;
               cnt_ff   <= '0;
               // silence maps straight to -160 dB
               level_ff <= LEVEL_ZERO;
            end
         end
         ST_LOG_ACC: begin
            // one log2 fraction bit per squaring
            frac_ff <= {frac_ff[14:0], log_sq[16]};
            y_ff    <= log_sq[16] ? log_sq[16:1] : log_sq[15:0];
            cnt_ff  <= cnt_ff + 4'd1;
         end
         ST_LOG_LVL: begin
            level_ff <= -$signed({2'b0, lvl_sum[38:24]});
         end
         ST_CURVE_E: begin
            e_ff <= {level_ff[16], level_ff} - {{2{thresh_ff[15]}}, thresh_ff};
         end
         ST_CURVE_SEL: begin
            in_knee_ff <= !below && !above;
            near_ff    <= e2_abs <= SLEW_LIMIT;
            curve_ff   <= level20;
         end
         ST_CURVE_HI: begin
            // above the knee: threshold plus overshoot scaled by 1/ratio
            curve_ff <= thresh20 + {3'b0, hi_sum[32:16]};
         end
         ST_KNEE_CURVE: begin
            // quadratic knee term
            curve_ff <= level20 - {2'b0, kn_sum[33:16]};
         end
         ST_REDUCE: begin
            if (r21[20]) begin
               red_in_ff <= '0;
            end else if (r21 > 21'sd32767) begin
               red_in_ff <= 15'h7FFF;
            end else begin
               red_in_ff <= r21[14:0];
            end
            // slew attack coefficient inside the knee, close to the threshold, on a rising curve
            slew_ff <= in_knee_ff && near_ff && (curve_ff >= prev20);
         end
         ST_EXP_T: begin
            n_ff   <= exp_sum[32:28];
            f_ff   <= exp_sum[27:12];
            g_ff   <= 31'h4000_0000;
            cnt_ff <= '0;
         end
         ST_GAIN_CHK: begin
            if (!f_ff[15]) begin
               f_ff   <= f_ff << 1;
               cnt_ff <= cnt_ff + 4'd1;
            end
         end
         ST_GAIN_UPD: begin
            g_ff   <= gain_sum[60:30];
            f_ff   <= f_ff << 1;
            cnt_ff <= cnt_ff + 4'd1;
         end
         ST_OUT: begin
            // the exponent integer part stays below 22, so the gain never underflows to zero
            if (x_ff[15]) begin
               res_sample_ff <= neg_mag[15:0];
            end else if (mag > 17'd32767) begin
               res_sample_ff <= 16'sh7FFF;
            end else begin
               res_sample_ff <= mag[15:0];
            end
         end
         default: ;
      endcase
   end

   // result register, refilled once the previous transfer leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sample_ff <= res_sample_ff;
         rsp_red_ff    <= smooth_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_sample        = rsp_sample_ff;
   assign rsp_gain_reduction_db = rsp_red_ff;

   // a result appears only out of the final sequencer step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish step");

   // the divider reports only while the sequencer waits for it
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider done while not waited for");

   // an accepted sample starts either the log or the silence path
   a_start_path: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_LOG_SQ || state_ff == ST_CURVE_E))
      else $error("accepted sample did not start processing");

endmodule

`default_nettype wire

### rtl/core/skc_mul.sv
// shared signed multiplier with registered product
`default_nettype none

module skc_mul (
   input  wire logic                                clock,
   input  wire logic signed [skc_pkg::MUL_W-1:0]    mul_a,
   input  wire logic signed [skc_pkg::MUL_W-1:0]    mul_b,
   output logic signed [skc_pkg::PROD_W-1:0]        mul_p
);
   import skc_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

`default_nettype wire

### rtl/core/skc_div.sv
// restoring divider for the knee term, one quotient bit per cycle
`default_nettype none

module skc_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire skc_pkg::div_req_type            div_req,
   output logic                                 div_done,
   output logic [skc_pkg::DIV_Q_W-1:0]          div_quot
);
   import skc_pkg::*;

   localparam int TRIAL_W = DIV_DEN_W + DIV_Q_W;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_NUM_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_Q_W-1:0]   quot_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [TRIAL_W-1:0]   trial;
   logic                 last;

   assign trial = TRIAL_W'(rem_ff) - (TRIAL_W'(den_ff) << cnt_ff);
   assign last  = busy_ff && (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff  <= div_req.dividend;
         den_ff  <= div_req.divisor;
         quot_ff <= '0;
         cnt_ff  <= '1;
      end else if (busy_ff) begin
         if (!trial[TRIAL_W-1]) begin
            rem_ff <= trial[DIV_NUM_W-1:0];
         end
         quot_ff <= {quot_ff[DIV_Q_W-2:0], !trial[TRIAL_W-1]};
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   assign div_done = done_ff;
   assign div_quot = quot_ff;

endmodule

`default_nettype wire

### tb/sv/tb_soft_knee_log_compressor_core.sv
// self-checking testbench of the soft knee log domain compressor core
`default_nettype none

module tb_soft_knee_log_compressor_core;
   timeunit 1ns;
   timeprecision 1ps;
   import skc_pkg::*;

   localparam int SETTLE_CYCLES = 200;    // longest single-sample latency with margin

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_in_sample = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic signed [15:0] rsp_out_sample;
   logic [14:0]        rsp_gain_reduction_db;
   logic               csr_wr_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   soft_knee_log_compressor_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_in_sample         (req_in_sample),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_sample        (rsp_out_sample),
      .rsp_gain_reduction_db (rsp_gain_reduction_db),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #2 clock = ~clock;

   typedef struct {
      logic signed [15:0] out_sample;
      logic [14:0]        reduction;
   } comp_result_type;

   // predictor copy of the registers and detector state
   int      thr_q8;
   int      knee_q8;
   longint  inv_q16;
   longint  atk_q16;
   longint  slew_q16;
   longint  rel_q16;
   int      last_curve;
   longint  peak_hold;
   longint  smooth_red;

   logic signed [15:0] sample_queue [$];     // samples waiting to be transferred
   comp_result_type    expected_queue [$];   // predicted results in order
   int  mismatches = 0;
   bit  idle_on = 1'b1;      // random idling enabled
   bit  hold_off = 1'b0;     // request for one long receiver stall
   bit  hold_active = 1'b0;

   function automatic longint int_root(longint unsigned v_in);
      longint unsigned v, r, b;
      v = v_in;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint db_level(longint m);
      int     p;
      longint y, frac, d;
      if (m == 0) return -40960;
      p = 15;
      while (((m >> p) & 1) == 0) p--;
      y = m << (15 - p);
      frac = 0;
      for (int k = 0; k < 16; k++) begin
         y = (y * y) >> 15;
         frac = frac << 1;
         if (y >= 65536) begin
            frac = frac | 1;
            y = y >> 1;
         end
      end
      d = (longint'(15) << 16) - ((longint'(p) << 16) | frac);
      return -((d * 394566 + (longint'(1) << 23)) >> 24);
   endfunction

   function automatic longint pole_blend(longint a, longint old_v, longint new_v);
      return (a * old_v + (65536 - a) * new_v + 32768) >> 16;
   endfunction

   function automatic longint gain_q30(longint red);
      longint t, n, f, g, r;
      t = (red * 174165 + 2048) >> 12;
      n = t >> 16;
      f = t & 16'hFFFF;
      g = longint'(1) << 30;
      r = longint'(1) << 29;
      for (int k = 1; k <= 16; k++) begin
         r = int_root(r << 30);
         if ((f >> (16 - k)) & 1) g = (g * r + (longint'(1) << 29)) >> 30;
      end
      if (n >= 31) return 0;
      return g >> n;
   endfunction

   // compressor prediction for one sample, advances the detector state
   function automatic comp_result_type compress_sample(logic signed [15:0] x);
      comp_result_type res;
      longint m, lvl, e, w, curve, r, s, q, pk, rd, mag, y;
      bit     slew;
      m = (x < 0) ? -longint'(x) : longint'(x);
      w = 6 * knee_q8 + 3;
      lvl = db_level(m);
      e = lvl - thr_q8;
      slew = 1'b0;
      if (2 * e < -w) begin
         curve = lvl;
      end else if (2 * e > w) begin
         curve = thr_q8 + ((e * inv_q16 + 32768) >> 16);
      end else begin
         s = 2 * e + w;
         q = (s * s) / (8 * w);
         curve = lvl - ((q * (65536 - inv_q16) + 32768) >> 16);
         if ((e < 0 ? -2 * e : 2 * e) <= 461 && curve >= last_curve) slew = 1'b1;
      end
      r = lvl - curve;
      if (r < 0) r = 0;
      if (r > 32767) r = 32767;
      pk = pole_blend(rel_q16, peak_hold, r);
      if (pk < r) pk = r;
      rd = pole_blend(slew ? slew_q16 : atk_q16, smooth_red, pk);
      mag = (m * gain_q30(rd) + (longint'(1) << 29)) >> 30;
      y = (x < 0) ? -mag : mag;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      peak_hold = pk;
      smooth_red = rd;
      if (curve > 32767) curve = 32767;
      if (curve < -32768) curve = -32768;
      last_curve = int'(curve);
      res.out_sample = y[15:0];
      res.reduction = rd[14:0];
      return res;
   endfunction

   // driver: one transfer per accepted cycle, predicts when accepted
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_queue.push_back(compress_sample(req_in_sample));
            void'(sample_queue.pop_front());
         end
         if (req_valid && req_stall) begin
            // payload holds while stalled
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 5);
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_in_sample <= sample_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: random bursts, plus one long hold-off on request
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_off && !hold_active) begin
            hold_active <= 1'b1;
            stall_left <= 600;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      comp_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result out=%0d red=%0d", rsp_out_sample,
                        rsp_gain_reduction_db);
         end else begin
            exp_r = expected_queue.pop_front();
            if (exp_r.out_sample !== rsp_out_sample
                || exp_r.reduction !== rsp_gain_reduction_db) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected out=%0d red=%0d, got out=%0d red=%0d",
                           exp_r.out_sample, exp_r.reduction, rsp_out_sample,
                           rsp_gain_reduction_db);
            end
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_THRESHOLD:  thr_q8 = int'($signed(val));
         CSR_KNEE:       knee_q8 = int'(val[11:0]);
         CSR_INV_RATIO:  inv_q16 = val;
         CSR_ATTACK:     atk_q16 = val;
         CSR_ATTACK_SLW: slew_q16 = val;
         CSR_RELEASE:    rel_q16 = val;
         default: ;
      endcase
   endtask

   task automatic drain_all();
      wait (sample_queue.size() == 0 && !req_valid && expected_queue.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 15)) - 16'd8;
         1: return 16'($urandom_range(0, 255)) << $urandom_range(0, 8);
         2: return -(16'($urandom_range(0, 255)) << $urandom_range(0, 7));
         default: return 16'($urandom);
      endcase
   endfunction

   // random settings of every register, with random ignored upper knee bits, then count random samples
   task automatic random_phase(input int count);
      logic [15:0] thr;
      thr = -16'($urandom_range(0, 20480));
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_KNEE, 16'($urandom_range(0, 2048)) | (16'($urandom) & 16'hF000));
      write_reg(CSR_INV_RATIO, 16'($urandom_range(13107, 65535)));
      write_reg(CSR_ATTACK, 16'($urandom));
      write_reg(CSR_ATTACK_SLW, 16'($urandom));
      write_reg(CSR_RELEASE, 16'($urandom));
      for (int i = 0; i < count; i++) sample_queue.push_back(rand_sample());
      drain_all();
   endtask

   initial begin
      thr_q8 = 0; knee_q8 = 0; inv_q16 = 43691; atk_q16 = 65399;
      slew_q16 = 65399; rel_q16 = 65518;
      last_curve = 0; peak_hold = 0; smooth_red = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes and zero at reset settings
      sample_queue.push_back(16'sh7FFF);
      sample_queue.push_back(-16'sh8000);
      sample_queue.push_back(16'sh0000);
      sample_queue.push_back(16'sh0001);
      sample_queue.push_back(-16'sh0001);
      sample_queue.push_back(16'sh4000);
      sample_queue.push_back(16'sh7FFF);
      sample_queue.push_back(16'sh0000);
      drain_all();

      // extreme settings: lowest threshold, widest knee, hardest ratio, fast attack and release, slowest slew
      write_reg(CSR_THRESHOLD, -16'sd20480);
      write_reg(CSR_KNEE, 16'd2048);
      write_reg(CSR_INV_RATIO, 16'd13107);
      write_reg(CSR_ATTACK, 16'd0);
      write_reg(CSR_ATTACK_SLW, 16'd65535);
      write_reg(CSR_RELEASE, 16'd0);
      write_reg(3'd7, 16'hFFFF);   // index beyond the last register
      sample_queue.push_back(16'sh7FFF);
      sample_queue.push_back(-16'sh8000);
      sample_queue.push_back(16'sh0000);
      sample_queue.push_back(16'sh0010);
      sample_queue.push_back(16'sh0008);
      drain_all();

      // slew zone: sweep up to a -6 dB threshold with narrow knee
      write_reg(CSR_THRESHOLD, -16'sd1536);
      write_reg(CSR_KNEE, 16'hF050);       // upper bits ignored
      write_reg(CSR_INV_RATIO, 16'd65535);
      write_reg(CSR_ATTACK, 16'd65535);
      write_reg(CSR_ATTACK_SLW, 16'd0);
      write_reg(CSR_RELEASE, 16'd65535);
      for (int i = 0; i < 8; i++) sample_queue.push_back(16'sd12000 + 16'(i * 600));
      drain_all();

      // long receiver hold-off while the sender keeps offering
      for (int i = 0; i < 40; i++) sample_queue.push_back(rand_sample());
      hold_off = 1'b1;
      drain_all();
      hold_off = 1'b0;

      for (int ph = 0; ph < 8; ph++) random_phase(200);
      idle_on = 1'b0;
      random_phase(250);

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/core/skc_pkg.sv
rtl/core/skc_mul.sv
rtl/core/skc_div.sv
rtl/core/soft_knee_log_compressor_core.sv
tb/sv/tb_soft_knee_log_compressor_core.sv
